### src/bounded_deque_with_remove_core_defines.svh
// ----------------------------------------------------------------------------
// bounded deque assertion macros
// shared property forms for the deque core checks
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_WITH_REMOVE_CORE_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_REMOVE_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define BDQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define BDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### src/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// types, codes and constants shared by the bounded deque core
// ----------------------------------------------------------------------------
package bdq_pkg;

	// fixed field widths
	localparam int HANDLE_W  = 32;
	localparam int OCC_W     = 5;
	localparam int CFG_W     = 5;
	localparam int ACTION_W  = 3;
	localparam int STATUS_W  = 2;

	// default slot store depth
	localparam int DEPTH_DEF = 16;

	// request actions
	localparam logic [ACTION_W-1:0] ACT_APPEND   = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_POP_HEAD = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_POP_TAIL = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_REMOVE   = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_COUNT    = 3'd4;

	// response status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [HANDLE_W-1:0] handle;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [HANDLE_W-1:0] handle_out;
		logic [OCC_W-1:0]    occupancy_out;
	} rsp_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_START,
		S_APPEND,
		S_POPH,
		S_TWALK,
		S_RWALK,
		S_RFIX,
		S_FREE,
		S_DONE
	} state_t;

endpackage

### src/bounded_deque_with_remove_core.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_remove_core: handle queue over a linked slot store
// count, full and empty results go from start to done; append hooks the free slot behind the tail
// pop head and pop tail free a slot, pop tail after a walk to the entry before the tail; remove walks to the match
// one request at a time; next request taken the cycle after the result leaves
// reset: free-list sweep through the link ram, stall held high
// ----------------------------------------------------------------------------
`include "bounded_deque_with_remove_core_defines.svh"

module bounded_deque_with_remove_core #(
	parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  bdq_pkg::req_t             req,
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output bdq_pkg::rsp_t             rsp,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [bdq_pkg::CFG_W-1:0] cfg_data
);

	localparam int AW = $clog2(DEPTH);
	localparam int HW = bdq_pkg::HANDLE_W;

	logic [bdq_pkg::CFG_W-1:0] cap_q;
	logic                      ctrl_ready;
	logic                      res_valid;
	bdq_pkg::rsp_t             res;
	logic                      res_take;
	logic                      rsp_valid_q;
	bdq_pkg::rsp_t             rsp_q;

	logic          link_we;
	logic [AW-1:0] link_waddr;
	logic [AW-1:0] link_wdata;
	logic          link_re;
	logic [AW-1:0] link_raddr;
	logic [AW-1:0] link_rdata;
	logic          hnd_we;
	logic [AW-1:0] hnd_waddr;
	logic [HW-1:0] hnd_wdata;
	logic          hnd_re;
	logic [AW-1:0] hnd_raddr;
	logic [HW-1:0] hnd_rdata;

	// capacity limit register, always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	// sequencer
	bdq_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req        (req),
		.ready      (ctrl_ready),
		.cap        (cap_q),
		.res_valid  (res_valid),
		.res        (res),
		.res_take   (res_take),
		.link_we    (link_we),
		.link_waddr (link_waddr),
		.link_wdata (link_wdata),
		.link_re    (link_re),
		.link_raddr (link_raddr),
		.link_rdata (link_rdata),
		.hnd_we     (hnd_we),
		.hnd_waddr  (hnd_waddr),
		.hnd_wdata  (hnd_wdata),
		.hnd_re     (hnd_re),
		.hnd_raddr  (hnd_raddr),
		.hnd_rdata  (hnd_rdata)
	);

	assign req_stall = !ctrl_ready;

	// next-slot links
	bdq_ram #(
		.WIDTH(AW),
		.DEPTH(DEPTH)
	) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.re    (link_re),
		.raddr (link_raddr),
		.rdata (link_rdata)
	);

	// handle store
	bdq_ram #(
		.WIDTH(HW),
		.DEPTH(DEPTH)
	) u_hnd_ram (
		.clk   (clk),
		.we    (hnd_we),
		.waddr (hnd_waddr),
		.wdata (hnd_wdata),
		.re    (hnd_re),
		.raddr (hnd_raddr),
		.rdata (hnd_rdata)
	);

	// output register, loads when empty or being drained
	assign res_take = res_valid && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// checks
	`BDQ_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall, "request taken while busy")
	`BDQ_ASSERT_NOW(a_fail_no_handle, rsp_valid && (rsp.status != bdq_pkg::ST_OK), rsp.handle_out == '0, "failed request returned a handle")
	`BDQ_ASSERT_NOW(a_empty_zero_occ, rsp_valid && (rsp.status == bdq_pkg::ST_EMPTY), rsp.occupancy_out == '0, "empty status with nonzero occupancy")
	`BDQ_ASSERT_NOW(a_occ_bound, rsp_valid, 32'(rsp.occupancy_out) <= 32'(DEPTH), "occupancy above store depth")

endmodule

### src/bdq_ram.sv
// ----------------------------------------------------------------------------
// bdq_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module bdq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### src/bdq_ctrl.sv
// ----------------------------------------------------------------------------
// bdq_ctrl
// list sequencer: walks the slot links one entry per cycle, with a single
// handle comparator for removal, and updates head, tail, free list and occupancy
// ----------------------------------------------------------------------------
module bdq_ctrl #(
	parameter int DEPTH = bdq_pkg::DEPTH_DEF,
	localparam int AW = $clog2(DEPTH),
	localparam int HW = bdq_pkg::HANDLE_W
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	input  bdq_pkg::req_t            req,
	output logic                     ready,
	input  logic [bdq_pkg::CFG_W-1:0] cap,
	output logic                     res_valid,
	output bdq_pkg::rsp_t            res,
	input  logic                     res_take,
	output logic                     link_we,
	output logic [AW-1:0]            link_waddr,
	output logic [AW-1:0]            link_wdata,
	output logic                     link_re,
	output logic [AW-1:0]            link_raddr,
	input  logic [AW-1:0]            link_rdata,
	output logic                     hnd_we,
	output logic [AW-1:0]            hnd_waddr,
	output logic [HW-1:0]            hnd_wdata,
	output logic                     hnd_re,
	output logic [AW-1:0]            hnd_raddr,
	input  logic [HW-1:0]            hnd_rdata
);

	localparam int OW = $clog2(DEPTH + 1);
	localparam int CW = (OW > bdq_pkg::CFG_W) ? OW : bdq_pkg::CFG_W;

	bdq_pkg::state_t state_q, state_d;
	bdq_pkg::req_t   req_q, req_d;

	logic [AW-1:0] head_q, head_d;
	logic [AW-1:0] tail_q, tail_d;
	logic [AW-1:0] free_q, free_d;
	logic [AW-1:0] slot_q, slot_d;
	logic [AW-1:0] prev_q, prev_d;
	logic [AW-1:0] next_q, next_d;
	logic [AW-1:0] init_q, init_d;
	logic [OW-1:0] occ_q, occ_d;
	logic [OW-1:0] cnt_q, cnt_d;

	logic [bdq_pkg::STATUS_W-1:0] status_q, status_d;
	logic [HW-1:0]                hout_q, hout_d;

	logic [CW-1:0] cap_w;
	logic [CW-1:0] occ_w;
	logic [CW-1:0] dep_w;
	logic          limit_full;
	logic          is_full;
	logic          hit;
	logic          walk_last;

	// capacity check, zero or oversized limit means the whole store
	always_comb begin
		cap_w      = CW'(cap);
		occ_w      = CW'(occ_q);
		dep_w      = CW'(DEPTH);
		limit_full = (cap_w == '0) || (cap_w > dep_w);
		is_full    = limit_full ? (occ_w >= dep_w) : (occ_w >= cap_w);
	end

	// single handle comparator for the removal walk
	assign hit       = (hnd_rdata == req_q.handle);
	assign walk_last = (OW'(cnt_q + OW'(1)) == occ_q);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bdq_pkg::S_INIT;
			head_q  <= '0;
			tail_q  <= '0;
			free_q  <= '0;
			occ_q   <= '0;
			init_q  <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			free_q  <= free_d;
			occ_q   <= occ_d;
			init_q  <= init_d;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		req_q    <= req_d;
		slot_q   <= slot_d;
		prev_q   <= prev_d;
		next_q   <= next_d;
		cnt_q    <= cnt_d;
		status_q <= status_d;
		hout_q   <= hout_d;
	end

	// sequencer next state and ram control
	always_comb begin
		state_d  = state_q;
		req_d    = req_q;
		head_d   = head_q;
		tail_d   = tail_q;
		free_d   = free_q;
		slot_d   = slot_q;
		prev_d   = prev_q;
		next_d   = next_q;
		occ_d    = occ_q;
		cnt_d    = cnt_q;
		init_d   = init_q;
		status_d = status_q;
		hout_d   = hout_q;

		ready      = 1'b0;
		link_we    = 1'b0;
		link_waddr = slot_q;
		link_wdata = free_q;
		link_re    = 1'b0;
		link_raddr = head_q;
		hnd_we     = 1'b0;
		hnd_waddr  = free_q;
		hnd_wdata  = req_q.handle;
		hnd_re     = 1'b0;
		hnd_raddr  = head_q;

		case (state_q)
			// chain every slot into the free list after reset
			bdq_pkg::S_INIT: begin
				link_we    = 1'b1;
				link_waddr = init_q;
				if (init_q == AW'(DEPTH - 1)) begin
					link_wdata = '0;
					state_d    = bdq_pkg::S_IDLE;
				end else begin
					link_wdata = AW'(init_q + AW'(1));
					init_d     = AW'(init_q + AW'(1));
				end
			end

			bdq_pkg::S_IDLE: begin
				ready = 1'b1;
				if (req_valid) begin
					req_d    = req;
					status_d = bdq_pkg::ST_OK;
					hout_d   = '0;
					state_d  = bdq_pkg::S_START;
				end
			end

			// check the request and issue the first reads
			bdq_pkg::S_START: begin
				case (req_q.action)
					bdq_pkg::ACT_APPEND: begin
						if (is_full) begin
							status_d = bdq_pkg::ST_FULL;
							state_d  = bdq_pkg::S_DONE;
						end else begin
							hnd_we     = 1'b1;
							hnd_waddr  = free_q;
							link_re    = 1'b1;
							link_raddr = free_q;
							slot_d     = free_q;
							state_d    = bdq_pkg::S_APPEND;
						end
					end
					bdq_pkg::ACT_POP_HEAD: begin
						if (occ_q == '0) begin
							status_d = bdq_pkg::ST_EMPTY;
							state_d  = bdq_pkg::S_DONE;
						end else begin
							link_re    = 1'b1;
							link_raddr = head_q;
							hnd_re     = 1'b1;
							hnd_raddr  = head_q;
							slot_d     = head_q;
							state_d    = bdq_pkg::S_POPH;
						end
					end
					bdq_pkg::ACT_POP_TAIL: begin
						if (occ_q == '0) begin
							status_d = bdq_pkg::ST_EMPTY;
							state_d  = bdq_pkg::S_DONE;
						end else begin
							link_re    = 1'b1;
							link_raddr = head_q;
							hnd_re     = 1'b1;
							hnd_raddr  = tail_q;
							slot_d     = tail_q;
							prev_d     = head_q;
							cnt_d      = OW'(occ_q - OW'(2));
							state_d    = bdq_pkg::S_TWALK;
						end
					end
					bdq_pkg::ACT_REMOVE: begin
						if (occ_q == '0) begin
							status_d = bdq_pkg::ST_EMPTY;
							state_d  = bdq_pkg::S_DONE;
						end else begin
							link_re    = 1'b1;
							link_raddr = head_q;
							hnd_re     = 1'b1;
							hnd_raddr  = head_q;
							slot_d     = head_q;
							prev_d     = head_q;
							cnt_d      = '0;
							state_d    = bdq_pkg::S_RWALK;
						end
					end
					default: begin
						state_d = bdq_pkg::S_DONE;
					end
				endcase
			end

			// take the free slot and hook it behind the tail
			bdq_pkg::S_APPEND: begin
				free_d = link_rdata;
				if (occ_q == '0) begin
					head_d = slot_q;
				end else begin
					link_we    = 1'b1;
					link_waddr = tail_q;
					link_wdata = slot_q;
				end
				tail_d  = slot_q;
				occ_d   = OW'(occ_q + OW'(1));
				state_d = bdq_pkg::S_DONE;
			end

			bdq_pkg::S_POPH: begin
				hout_d  = hnd_rdata;
				head_d  = link_rdata;
				state_d = bdq_pkg::S_FREE;
			end

			// walk from the head to the entry before the tail
			bdq_pkg::S_TWALK: begin
				if (occ_q == OW'(1)) begin
					hout_d  = hnd_rdata;
					state_d = bdq_pkg::S_FREE;
				end else if (cnt_q == '0) begin
					hout_d  = hnd_rdata;
					tail_d  = prev_q;
					state_d = bdq_pkg::S_FREE;
				end else begin
					prev_d     = link_rdata;
					cnt_d      = OW'(cnt_q - OW'(1));
					link_re    = 1'b1;
					link_raddr = link_rdata;
				end
			end

			// search from the head, one entry per cycle
			bdq_pkg::S_RWALK: begin
				if (hit) begin
					next_d  = link_rdata;
					hout_d  = req_q.handle;
					state_d = bdq_pkg::S_RFIX;
				end else if (walk_last) begin
					status_d = bdq_pkg::ST_NOTFOUND;
					state_d  = bdq_pkg::S_DONE;
				end else begin
					prev_d     = slot_q;
					slot_d     = link_rdata;
					cnt_d      = OW'(cnt_q + OW'(1));
					link_re    = 1'b1;
					link_raddr = link_rdata;
					hnd_re     = 1'b1;
					hnd_raddr  = link_rdata;
				end
			end

			// unlink the matched slot
			bdq_pkg::S_RFIX: begin
				if (cnt_q == '0) begin
					head_d = next_q;
				end else begin
					link_we    = 1'b1;
					link_waddr = prev_q;
					link_wdata = next_q;
					if (walk_last) begin
						tail_d = prev_q;
					end
				end
				state_d = bdq_pkg::S_FREE;
			end

			// push the released slot onto the free list
			bdq_pkg::S_FREE: begin
				link_we    = 1'b1;
				link_waddr = slot_q;
				link_wdata = free_q;
				free_d     = slot_q;
				occ_d      = OW'(occ_q - OW'(1));
				state_d    = bdq_pkg::S_DONE;
			end

			bdq_pkg::S_DONE: begin
				if (res_take) begin
					state_d = bdq_pkg::S_IDLE;
				end
			end

			default: begin
				state_d = bdq_pkg::S_IDLE;
			end
		endcase
	end

	// result toward the output register
	assign res_valid         = (state_q == bdq_pkg::S_DONE);
	assign res.status        = status_q;
	assign res.handle_out    = hout_q;
	assign res.occupancy_out = bdq_pkg::OCC_W'(occ_q);

endmodule
